### sv/ocvm_pkg.sv
// Shared types, constants and helper functions for the orbit camera view matrix unit.
`timescale 1ns / 1ps
`default_nettype none
package ocvm_pkg;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_FORCE  = 2'd1,
    OP_POSE   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ROW_SIDE  = 3'd0,
    ROW_UP    = 3'd1,
    ROW_FWD   = 3'd2,
    ROW_TRANS = 3'd3,
    ROW_CAM   = 3'd4
  } row_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_SIN_T,
    ST_SIN_P,
    ST_POSE,
    ST_OUT
  } state_t;

  typedef logic signed [19:0] trig_t;
  typedef logic signed [15:0] angle_t;
  typedef logic signed [66:0] wide_t;

  typedef struct packed {
    logic  done;
    trig_t sin_v;
    trig_t cos_v;
  } sincos_t;

  localparam angle_t ANG_PI_Q      = 16'sd25736;
  localparam angle_t ANG_HALF_PI_Q = 16'sd12868;
  localparam angle_t THETA_MIN     = 16'sd8;
  localparam angle_t THETA_MAX     = 16'sd25723;
  localparam logic signed [21:0] ANG_TWO_PI_Q = 22'sd51472;
  localparam logic signed [32:0] DEG_TO_RAD   = 33'sd73205;
  localparam logic signed [32:0] HALF_PI_MUL  = 33'sd12868;
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic [3:0] CORDIC_LAST = 4'd15;

  function automatic logic signed [21:0] atan_lut(input logic [3:0] idx);
    logic signed [21:0] v;
    case (idx)
      4'd0:    v = 22'sd51472;
      4'd1:    v = 22'sd30385;
      4'd2:    v = 22'sd16055;
      4'd3:    v = 22'sd8150;
      4'd4:    v = 22'sd4091;
      4'd5:    v = 22'sd2047;
      4'd6:    v = 22'sd1024;
      4'd7:    v = 22'sd512;
      4'd8:    v = 22'sd256;
      4'd9:    v = 22'sd128;
      4'd10:   v = 22'sd64;
      4'd11:   v = 22'sd32;
      4'd12:   v = 22'sd16;
      4'd13:   v = 22'sd8;
      4'd14:   v = 22'sd4;
      default: v = 22'sd2;
    endcase
    return v;
  endfunction

  // round half up, divide by 2^16
  function automatic wide_t rnd16(input wide_t v);
    wide_t t;
    t = v + 67'sd32768;
    return t >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t v);
    logic signed [31:0] r;
    if (v > 67'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -67'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic angle_t clamp_theta(input logic signed [21:0] t);
    angle_t r;
    if (t < 22'(THETA_MIN)) begin
      r = THETA_MIN;
    end else if (t > 22'(THETA_MAX)) begin
      r = THETA_MAX;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

  // one fold suffices for every reachable sum
  function automatic angle_t wrap_phi(input logic signed [21:0] p);
    logic signed [21:0] r;
    r = p;
    if (p >= 22'(ANG_PI_Q)) begin
      r = p - ANG_TWO_PI_Q;
    end else if (p < -22'(ANG_PI_Q)) begin
      r = p + ANG_TWO_PI_Q;
    end
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

### sv/ocvm_cordic.sv
// Iterative 16-step CORDIC giving sine and cosine of a Q3.13 angle in Q4.16.
`timescale 1ns / 1ps
`default_nettype none
module ocvm_cordic (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire ocvm_pkg::angle_t angle,
  output ocvm_pkg::sincos_t    res
);
  import ocvm_pkg::*;

  logic               busy_r, done_r, neg_r;
  logic [3:0]         idx_r;
  logic signed [33:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [21:0] z_r, z_nxt, z_init;
  logic signed [16:0] fold;
  logic               neg_nxt;
  logic signed [33:0] xr, yr;
  trig_t              s_v, c_v;

  // fold into [-pi/2, pi/2]
  always_comb begin
    fold    = 17'(angle);
    neg_nxt = 1'b0;
    if (angle > ANG_HALF_PI_Q) begin
      fold    = 17'(angle) - 17'(ANG_PI_Q);
      neg_nxt = 1'b1;
    end else if (angle < -ANG_HALF_PI_Q) begin
      fold    = 17'(angle) + 17'(ANG_PI_Q);
      neg_nxt = 1'b1;
    end
    z_init = 22'(fold) <<< 3;
  end

  always_comb begin
    xs = x_r >>> idx_r;
    ys = y_r >>> idx_r;
    if (z_r >= 0) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - atan_lut(idx_r);
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + atan_lut(idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= busy_r && (idx_r == CORDIC_LAST);
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        idx_r <= idx_r + 4'd1;
        if (idx_r == CORDIC_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= CORDIC_GAIN;
      y_r   <= '0;
      z_r   <= z_init;
      neg_r <= neg_nxt;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  always_comb begin
    xr  = (x_r + 34'sd8192) >>> 14;
    yr  = (y_r + 34'sd8192) >>> 14;
    s_v = neg_r ? -yr[19:0] : yr[19:0];
    c_v = neg_r ? -xr[19:0] : xr[19:0];
  end

  assign res = '{done: done_r, sin_v: s_v, cos_v: c_v};

endmodule
`default_nettype wire

### sv/orbit_camera_view_matrix_unit.sv
// Top level: orbit angle state, shared multiplier sequencer and pose row output.
// Update and force items pass through the angle multiplier steps before the next item is taken.
// A pose item runs two CORDIC passes (theta, then phi) and 15 multiplier steps before its
// first row, then presents five rows, one per output handshake; the next item is taken
// after the handshake of the last row.
// Synchronous active-low reset: theta = pi/2, phi = -pi/2, no rows pending.
`timescale 1ns / 1ps
`default_nettype none
module orbit_camera_view_matrix_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic signed [15:0] in_stick_axis,
  input  wire logic [15:0]        in_delta_time,
  input  wire logic signed [15:0] in_forward_rotation,
  input  wire logic signed [15:0] in_force_horizontal,
  input  wire logic signed [15:0] in_force_vertical,
  input  wire logic signed [31:0] in_focus_x,
  input  wire logic signed [31:0] in_focus_y,
  input  wire logic signed [31:0] in_focus_z,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [2:0]         out_row_kind,
  output      logic signed [31:0] out_value_x,
  output      logic signed [31:0] out_value_y,
  output      logic signed [31:0] out_value_z,
  output      logic               out_last_row
);
  import ocvm_pkg::*;

  state_t    state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  row_kind_t row_r, row_nxt;
  opcode_t   op_r;
  angle_t    theta_r, theta_nxt, phi_r, phi_nxt;
  logic signed [15:0] stick_r, fr_r, fh_r, fv_r;
  logic [15:0] dt_r;
  logic signed [31:0] foc_r [3];
  trig_t st_r, ct_r, sp_r, cp_r;
  trig_t d0_r, d1_r, u0_r, u1_r, u2_r, tmp_r;
  trig_t d0_nxt, d1_nxt, u0_nxt, u1_nxt, u2_nxt, tmp_nxt;
  logic signed [31:0] cam_r [3];
  logic signed [31:0] cam_nxt [3];
  logic signed [31:0] r3_r [3];
  logic signed [31:0] r3_nxt [3];
  wide_t prod_r, acc_r, acc_nxt, rp, sum, sh;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic cam_load;
  logic in_acc, cs_start;
  angle_t cs_angle;
  sincos_t cs_res;
  wide_t chg;
  trig_t dsel [3];

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign cs_start = (in_acc && (opcode_t'(in_opcode) == OP_POSE))
                    || (state_r == ST_SIN_T && cs_res.done);
  assign cs_angle = (state_r == ST_IDLE) ? theta_r : phi_r;

  ocvm_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cs_start),
    .angle (cs_angle),
    .res   (cs_res)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign rp   = rnd16(prod_r);
  assign sum  = acc_r + prod_r;
  assign sh   = sum >>> 16;
  assign chg  = (prod_r + 67'sd536870912) >>> 30;
  assign dsel = '{d0_r, d1_r, ct_r};

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    row_nxt   = row_r;
    theta_nxt = theta_r;
    phi_nxt   = phi_r;
    d0_nxt = d0_r; d1_nxt = d1_r;
    u0_nxt = u0_r; u1_nxt = u1_r; u2_nxt = u2_r; tmp_nxt = tmp_r;
    r3_nxt  = r3_r;
    acc_nxt = acc_r;
    cam_load = 1'b0;
    mul_a = '0;
    mul_b = '0;
    for (int j = 0; j < 3; j++) begin
      cam_nxt[j] = sat32(67'(foc_r[j]) + (67'(dsel[j]) <<< 2));
    end
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_acc) begin
          case (opcode_t'(in_opcode))
            OP_UPDATE, OP_FORCE: state_nxt = ST_ANGLE;
            OP_POSE:             state_nxt = ST_SIN_T;
            default:             state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ANGLE: begin
        step_nxt = step_r + 4'd1;
        if (op_r == OP_UPDATE) begin
          case (step_r)
            4'd0: begin
              mul_a   = 34'(stick_r);
              mul_b   = HALF_PI_MUL;
              phi_nxt = wrap_phi(22'(fr_r) - 22'(ANG_HALF_PI_Q));
            end
            4'd1: begin
              mul_a = prod_r[33:0];
              mul_b = {17'd0, dt_r};
            end
            default: begin
              theta_nxt = clamp_theta(22'(theta_r) + chg[21:0]);
              state_nxt = ST_IDLE;
            end
          endcase
        end else begin
          case (step_r)
            4'd0: begin
              mul_a = 34'(fh_r);
              mul_b = DEG_TO_RAD;
            end
            4'd1: begin
              mul_a   = 34'(fv_r);
              mul_b   = DEG_TO_RAD;
              phi_nxt = wrap_phi(22'(phi_r) + rp[21:0]);
            end
            default: begin
              theta_nxt = clamp_theta(22'(theta_r) + rp[21:0]);
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SIN_T: begin
        if (cs_res.done) state_nxt = ST_SIN_P;
      end
      ST_SIN_P: begin
        if (cs_res.done) begin
          state_nxt = ST_POSE;
          step_nxt  = '0;
        end
      end
      ST_POSE: begin
        step_nxt = step_r + 4'd1;
        // issue this step's product, retire the previous one
        case (step_r)
          4'd0: begin mul_a = 34'(st_r); mul_b = 33'(cp_r); end
          4'd1: begin
            mul_a = 34'(st_r); mul_b = 33'(sp_r);
            d0_nxt = rp[19:0];
          end
          4'd2: begin
            mul_a = 34'(cp_r); mul_b = -33'(ct_r);
            d1_nxt = rp[19:0];
          end
          4'd3: begin
            mul_a = 34'(sp_r); mul_b = 33'(ct_r);
            u0_nxt = rp[19:0];
            cam_load = 1'b1;
          end
          4'd4: begin
            mul_a = -34'(sp_r); mul_b = -33'(d1_r);
            u1_nxt = -rp[19:0];
          end
          4'd5: begin
            mul_a = 34'(cp_r); mul_b = -33'(d0_r);
            tmp_nxt = rp[19:0];
          end
          4'd6: begin
            mul_a = -34'(sp_r); mul_b = 33'(cam_r[0]);
            u2_nxt = tmp_r - rp[19:0];
          end
          4'd7: begin
            mul_a = 34'(cp_r); mul_b = 33'(cam_r[1]);
            acc_nxt = prod_r + 67'sd32768;
          end
          4'd8: begin
            mul_a = 34'(u0_r); mul_b = 33'(cam_r[0]);
            r3_nxt[0] = sat32(-sh);
          end
          4'd9: begin
            mul_a = 34'(u1_r); mul_b = 33'(cam_r[1]);
            acc_nxt = prod_r + 67'sd32768;
          end
          4'd10: begin
            mul_a = 34'(u2_r); mul_b = 33'(cam_r[2]);
            acc_nxt = sum;
          end
          4'd11: begin
            mul_a = -34'(d0_r); mul_b = 33'(cam_r[0]);
            r3_nxt[1] = sat32(-sh);
          end
          4'd12: begin
            mul_a = -34'(d1_r); mul_b = 33'(cam_r[1]);
            acc_nxt = prod_r + 67'sd32768;
          end
          4'd13: begin
            mul_a = -34'(ct_r); mul_b = 33'(cam_r[2]);
            acc_nxt = sum;
          end
          default: begin
            r3_nxt[2] = sat32(sh);
            state_nxt = ST_OUT;
            row_nxt   = ROW_SIDE;
          end
        endcase
      end
      ST_OUT: begin
        if (out_ready) begin
          if (row_r == ROW_CAM) begin
            state_nxt = ST_IDLE;
          end else begin
            row_nxt = row_kind_t'(row_r + 3'd1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      row_r   <= ROW_SIDE;
      theta_r <= ANG_HALF_PI_Q;
      phi_r   <= -ANG_HALF_PI_Q;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      row_r   <= row_nxt;
      theta_r <= theta_nxt;
      phi_r   <= phi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= opcode_t'(in_opcode);
      stick_r  <= in_stick_axis;
      dt_r     <= in_delta_time;
      fr_r     <= in_forward_rotation;
      fh_r     <= in_force_horizontal;
      fv_r     <= in_force_vertical;
      foc_r[0] <= in_focus_x;
      foc_r[1] <= in_focus_y;
      foc_r[2] <= in_focus_z;
    end
    if (state_r == ST_SIN_T && cs_res.done) begin
      st_r <= cs_res.sin_v;
      ct_r <= cs_res.cos_v;
    end
    if (state_r == ST_SIN_P && cs_res.done) begin
      sp_r <= cs_res.sin_v;
      cp_r <= cs_res.cos_v;
    end
    d0_r <= d0_nxt; d1_r <= d1_nxt;
    u0_r <= u0_nxt; u1_r <= u1_nxt; u2_r <= u2_nxt; tmp_r <= tmp_nxt;
    acc_r <= acc_nxt;
    r3_r  <= r3_nxt;
    if (cam_load) cam_r <= cam_nxt;
  end

  // result row select
  always_comb begin
    out_value_x = '0;
    out_value_y = '0;
    out_value_z = '0;
    case (row_r)
      ROW_SIDE: begin
        out_value_x = -32'(sp_r);
        out_value_y = 32'(cp_r);
      end
      ROW_UP: begin
        out_value_x = 32'(u0_r);
        out_value_y = 32'(u1_r);
        out_value_z = 32'(u2_r);
      end
      ROW_FWD: begin
        out_value_x = 32'(d0_r);
        out_value_y = 32'(d1_r);
        out_value_z = 32'(ct_r);
      end
      ROW_TRANS: begin
        out_value_x = r3_r[0];
        out_value_y = r3_r[1];
        out_value_z = r3_r[2];
      end
      default: begin
        out_value_x = cam_r[0];
        out_value_y = cam_r[1];
        out_value_z = cam_r[2];
      end
    endcase
  end

  assign out_valid    = (state_r == ST_OUT);
  assign out_row_kind = row_r;
  assign out_last_row = (row_r == ROW_CAM);

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while rows pending");
  a_theta_range: assert property (@(posedge clk) disable iff (!rst_n)
    (theta_r >= THETA_MIN) && (theta_r <= THETA_MAX)) else $error("theta out of range");
  a_phi_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phi_r >= -ANG_PI_Q) && (phi_r < ANG_PI_Q)) else $error("phi not wrapped");
  a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_row) |=> in_ready)
    else $error("no return to idle after last row");

endmodule
`default_nettype wire
